// ===== src/xs128_pkg.sv =====
package xs128_pkg;

  localparam int unsigned WordWidth = 32;
  localparam int unsigned FracWidth = 23;

  localparam logic [WordWidth-1:0] InitX = 32'd123456789;
  localparam logic [WordWidth-1:0] InitY = 32'd362436069;
  localparam logic [WordWidth-1:0] InitZ = 32'd521288629;
  localparam logic [WordWidth-1:0] InitW = 32'd88675123;

  // Dividend of range mode is the word with its sign bit cleared.
  localparam int unsigned DvdWidth = WordWidth - 1;

  typedef enum logic [1:0] {
    OP_RAW   = 2'd0,
    OP_RANGE = 2'd1,
    OP_FRAC  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } req_t;

  typedef struct packed {
    logic signed [31:0] int_value;
    logic [22:0]        fraction;
    logic               span_error;
  } rsp_t;

endpackage

// ===== src/xs128_state.sv =====
module xs128_state (
  input  logic        clk,
  input  logic        rst,
  input  logic        reload,
  input  logic [31:0] seed,
  input  logic        advance,
  output logic [31:0] word
);
  import xs128_pkg::*;

  logic [WordWidth-1:0] word_x;
  logic [WordWidth-1:0] word_y;
  logic [WordWidth-1:0] word_z;
  logic [WordWidth-1:0] word_w;
  logic [WordWidth-1:0] t_mix;
  logic [WordWidth-1:0] w_next;
  logic                 seed_positive;

  assign t_mix         = word_x ^ (word_x << 11);
  assign w_next        = word_w ^ (word_w >> 19) ^ t_mix ^ (t_mix >> 8);
  assign seed_positive = (seed != '0) && !seed[WordWidth-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      word_x <= InitX;
      word_y <= InitY;
      word_z <= InitZ;
      word_w <= InitW;
    end else if (reload) begin
      word_x <= InitX;
      word_y <= InitY;
      word_z <= InitZ;
      word_w <= seed_positive ? seed : InitW;
    end else if (advance) begin
      word_x <= word_y;
      word_y <= word_z;
      word_z <= word_w;
      word_w <= w_next;
    end
  end

  assign word = word_w;

endmodule

// ===== src/xs128_divider.sv =====
module xs128_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] remainder
);
  import xs128_pkg::*;

  localparam int unsigned CntWidth = $clog2(DvdWidth + 1);

  logic [DvdWidth-1:0]  dvd;
  logic [WordWidth-1:0] dvs;
  logic [WordWidth-1:0] rem;
  logic [WordWidth-1:0] trial;
  logic [WordWidth-1:0] rem_next;
  logic [CntWidth-1:0]  cnt;
  logic                 busy;

  // Shift in one dividend bit, subtract the divisor when it fits.
  assign trial    = {rem[WordWidth-2:0], dvd[DvdWidth-1]};
  assign rem_next = (trial >= dvs) ? (trial - dvs) : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(DvdWidth);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[DvdWidth-2:0], 1'b0};
      rem <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

// ===== src/xorshift128_random_source.sv =====
// Xorshift128 random source with raw, range and fraction answers.
// Raw, fraction and unused opcodes and zero-span range requests pass from the
// input transfer to DONE, then the output register; other range requests pass
// LOAD and DIV first, where the bit-serial remainder unit retires one dividend
// bit per cycle over 31 bits. A new request is taken only back in IDLE.
// Reset (synchronous, rst high) loads the four words with their defaults.
module xorshift128_random_source (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  xs128_pkg::req_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output xs128_pkg::rsp_t out_data
);
  import xs128_pkg::*;

  state_t               state;
  state_t               state_next;

  // Request fields held for the duration of one item.
  opcode_t              op;
  logic [WordWidth-1:0] low;
  logic [WordWidth-1:0] mag;
  logic                 span_zero;

  logic [WordWidth-1:0] span;
  logic [WordWidth-1:0] span_mag;
  logic                 in_xfer;
  logic                 cfg_xfer;
  logic                 div_start;
  logic                 div_done;
  logic [WordWidth-1:0] div_rem;
  logic                 out_load;
  logic [WordWidth-1:0] word;
  rsp_t                 result;

  // Configuration always taken; user must send it only while idle; unchecked.
  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;
  assign in_xfer   = in_valid & in_ready;

  // Span with 32-bit wrap, then its magnitude read as unsigned.
  assign span     = WordWidth'(in_data.range_high) - WordWidth'(in_data.range_low);
  assign span_mag = span[WordWidth-1] ? (~span + 1'b1) : span;

  // Advance the generator on every input transfer; reload on a seed write.
  xs128_state u_state (
    .clk     (clk),
    .rst     (rst),
    .reload  (cfg_xfer),
    .seed    (cfg_data),
    .advance (in_xfer),
    .word    (word)
  );

  // Remainder of the sign-cleared word by the span magnitude.
  xs128_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (word[DvdWidth-1:0]),
    .divisor   (mag),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if ((in_data.opcode == OP_RANGE) && (span != '0)) begin
            state_next = ST_LOAD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_LOAD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: in_ready  = 1'b1;
      ST_LOAD: div_start = 1'b1;
      ST_DIV:  ;
      ST_DONE: out_load  = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request for the item in flight.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op        <= in_data.opcode;
      low       <= WordWidth'(in_data.range_low);
      mag       <= span_mag;
      span_zero <= (span == '0);
    end
  end

  // Form the answer from the stepped word and, in range mode, the remainder.
  always_comb begin
    result = '0;
    unique case (op)
      OP_RAW: begin
        result.int_value = word;
      end
      OP_RANGE: begin
        if (span_zero) begin
          result.span_error = 1'b1;
        end else begin
          result.int_value = div_rem + low;
        end
      end
      OP_FRAC: begin
        result.fraction = word[FracWidth-1:0];
      end
      OP_NONE: begin
        result = '0;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  // Output register: a waiting result does not stop the next input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

endmodule

// ===== bench/tb_xorshift128_random_source.sv =====
`timescale 1ns / 100ps

module tb_xorshift128_random_source;
  import xs128_pkg::*;

  localparam logic [31:0] IntMin = 32'h8000_0000;
  localparam logic [31:0] IntMax = 32'h7fff_ffff;
  localparam logic [31:0] Mask31 = 32'h7fff_ffff;
  localparam int unsigned NumPhases = 8;
  localparam int unsigned ItemsPerPhase = 180;
  // Range mode answers last, after the divider has run; leave slack beyond that.
  localparam int unsigned SettleCycles = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  rsp_t        out_data;

  // Requests waiting for the driver, and answers waiting for the monitor.
  req_t request_fifo[$];
  rsp_t predicted_rsps[$];

  // Percent of cycles in which the sender idles and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_zero_span = 0;
  int unsigned n_seeds = 0;
  int unsigned ops_sent[4] = '{0, 0, 0, 0};

  // Private copy of the generator words.
  logic [31:0] gen_x, gen_y, gen_z, gen_w;

  always #1 clk = ~clk;

  xorshift128_random_source u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Reload all four words; only a positive seed replaces the default w.
  function automatic void reload_words(input logic [31:0] seed_value);
    gen_x = InitX;
    gen_y = InitY;
    gen_z = InitZ;
    gen_w = (seed_value != '0 && !seed_value[31]) ? seed_value : InitW;
  endfunction

  // Advance the xorshift128 recurrence once and return the new w.
  function automatic logic [31:0] advance_words();
    logic [31:0] t;
    t = gen_x ^ (gen_x << 11);
    gen_x = gen_y;
    gen_y = gen_z;
    gen_z = gen_w;
    gen_w = gen_w ^ (gen_w >> 19) ^ t ^ (t >> 8);
    return gen_w;
  endfunction

  // Every request draws a word, whatever its opcode.
  function automatic rsp_t predict_draw(input req_t req);
    rsp_t        rsp;
    logic [31:0] word;
    logic [31:0] span;
    logic [31:0] mag;
    word = advance_words();
    rsp = '0;
    case (req.opcode)
      OP_RAW: begin
        rsp.int_value = word;
      end
      OP_RANGE: begin
        span = req.range_high - req.range_low;
        if (span == '0) begin
          rsp.span_error = 1'b1;
        end else begin
          // Magnitude read as unsigned, so a span of -2^31 gives 2^31.
          mag = span[31] ? (32'd0 - span) : span;
          rsp.int_value = ((word & Mask31) % mag) + req.range_low;
        end
      end
      OP_FRAC: begin
        rsp.fraction = word[22:0];
      end
      default: begin
      end
    endcase
    return rsp;
  endfunction

  function automatic req_t make_req(input opcode_t op, input logic [31:0] lo,
                                    input logic [31:0] hi);
    req_t req;
    req.opcode = op;
    req.range_low = lo;
    req.range_high = hi;
    return req;
  endfunction

  // Range requests most often, with spans that hit small, negative, zero and
  // extreme values; the rest spread over the other opcodes.
  function automatic req_t random_req();
    int unsigned pick;
    opcode_t     op;
    logic [31:0] lo;
    logic [31:0] hi;
    pick = $urandom_range(99);
    if (pick < 20) begin
      op = OP_RAW;
    end else if (pick < 65) begin
      op = OP_RANGE;
    end else if (pick < 92) begin
      op = OP_FRAC;
    end else begin
      op = OP_NONE;
    end
    lo = $urandom;
    hi = $urandom;
    case ($urandom_range(6))
      0: hi = lo + $urandom_range(1, 16);
      1: hi = lo - $urandom_range(1, 16);
      2: hi = lo;
      3: begin
        case ($urandom_range(3))
          0: lo = IntMin;
          1: lo = IntMax;
          2: lo = '0;
          default: lo = '1;
        endcase
      end
      4: hi = $urandom_range(1) ? IntMin : IntMax;
      default: begin
      end
    endcase
    return make_req(op, lo, hi);
  endfunction

  // Extremes of each field, every opcode, zero spans, negative spans and the
  // spans that wrap to a magnitude of one or of 2^31.
  task automatic queue_directed();
    request_fifo.push_back(make_req(OP_RAW, '0, '0));
    request_fifo.push_back(make_req(OP_FRAC, '0, '0));
    request_fifo.push_back(make_req(OP_NONE, '1, '1));
    request_fifo.push_back(make_req(OP_RANGE, 32'd0, 32'd1));
    request_fifo.push_back(make_req(OP_RANGE, 32'd0, 32'd0));
    request_fifo.push_back(make_req(OP_RANGE, IntMin, IntMin));
    request_fifo.push_back(make_req(OP_RANGE, IntMin, IntMax));
    request_fifo.push_back(make_req(OP_RANGE, IntMax, IntMin));
    request_fifo.push_back(make_req(OP_RANGE, 32'd0, IntMin));
    request_fifo.push_back(make_req(OP_RANGE, 32'd0, IntMax));
    request_fifo.push_back(make_req(OP_RANGE, -32'sd10, 32'sd10));
    request_fifo.push_back(make_req(OP_RANGE, 32'sd10, -32'sd10));
    request_fifo.push_back(make_req(OP_RANGE, '1, '0));
    request_fifo.push_back(make_req(OP_RANGE, IntMax, IntMax));
    request_fifo.push_back(make_req(OP_RAW, '1, '1));
    request_fifo.push_back(make_req(OP_FRAC, IntMax, IntMin));
    request_fifo.push_back(make_req(OP_RANGE, 32'd1000, 32'd1000000));
    request_fifo.push_back(make_req(OP_RANGE, IntMin, 32'd0));
    request_fifo.push_back(make_req(OP_NONE, '0, '0));
    request_fifo.push_back(make_req(OP_RANGE, 32'd100, 32'd7));
  endtask

  // Hold until every queued request has gone out and been answered.
  task automatic wait_drained();
    do @(posedge clk);
    while (request_fifo.size() != 0 || in_valid || predicted_rsps.size() != 0);
  endtask

  // Write the seed while the block is idle and reload the private words.
  task automatic write_seed(input logic [31:0] seed_value);
    cfg_data <= seed_value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    reload_words(seed_value);
    n_seeds++;
  endtask

  task automatic report_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
    n_errors++;
  endtask

  // Driver: on a transfer, predict the answer from the payload just taken,
  // then load the next request unless this cycle idles. Compute valid and
  // payload first so each gets a single assignment per edge.
  always @(posedge clk) begin
    logic next_valid;
    req_t next_req;
    next_valid = in_valid;
    next_req = in_data;
    if (rst) begin
      next_valid = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_rsps.push_back(predict_draw(in_data));
        ops_sent[in_data.opcode]++;
        next_valid = 1'b0;
      end
      if (!next_valid && request_fifo.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_req = request_fifo.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
    in_data <= next_req;
  end

  // Monitor: check each answer transfer against the oldest prediction, then
  // decide whether to stall next cycle.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_rsps.size() == 0) begin
          $display("%0t: unexpected answer, expected none, got %h", $time, out_data);
          n_errors++;
        end else begin
          want = predicted_rsps.pop_front();
          n_checked++;
          if (want.span_error) begin
            n_zero_span++;
          end
          if (out_data.int_value !== want.int_value) begin
            report_field("int_value", want.int_value, out_data.int_value);
          end
          if (out_data.fraction !== want.fraction) begin
            report_field("fraction", {9'd0, want.fraction}, {9'd0, out_data.fraction});
          end
          if (out_data.span_error !== want.span_error) begin
            report_field("span_error", {31'd0, want.span_error},
                         {31'd0, out_data.span_error});
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    logic [31:0] seeds[NumPhases];
    // Largest and smallest seed, one, zero, minus one, and random
    // positive, negative and unrestricted values.
    seeds[0] = IntMax;
    seeds[1] = IntMin;
    seeds[2] = 32'd1;
    seeds[3] = 32'd0;
    seeds[4] = '1;
    seeds[5] = {1'b0, 31'($urandom)} | 32'd1;
    seeds[6] = {1'b1, 31'($urandom)};
    seeds[7] = $urandom;

    reload_words('0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests on the default words, no idling.
    queue_directed();
    wait_drained();

    // Cycle through the idle patterns: none, sender idle, receiver stall,
    // both lightly.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_seed(seeds[p]);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 85;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 85;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      for (int unsigned i = 0; i < ItemsPerPhase; i++) begin
        request_fifo.push_back(random_req());
      end
      wait_drained();
    end

    // Let any stray answer show up before the verdict.
    repeat (SettleCycles) @(posedge clk);

    $display("Checked %0d answers: raw %0d, range %0d (%0d zero span), fraction %0d, unused %0d",
             n_checked, ops_sent[OP_RAW], ops_sent[OP_RANGE], n_zero_span,
             ops_sent[OP_FRAC], ops_sent[OP_NONE]);
    $display("Seed writes: %0d, over four idle and stall patterns", n_seeds);
    if (n_errors == 0 && predicted_rsps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Timeout with %0d answers outstanding", predicted_rsps.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== xorshift128_random_source.f =====
src/xs128_pkg.sv
src/xs128_state.sv
src/xs128_divider.sv
src/xorshift128_random_source.sv
bench/tb_xorshift128_random_source.sv
